### hdl/accel_six_point_calibrator_macros.svh
// Assertion macros shared by the calibrator checker.
`ifndef ACCEL_SIX_POINT_CALIBRATOR_MACROS_SVH
`define ACCEL_SIX_POINT_CALIBRATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/aspc_pkg.sv
// Shared types and constants of the six-point accelerometer calibrator.
`default_nettype none
package aspc_pkg;

	localparam int LOG2_SAMPLES_DEF = 9;
	localparam int SL_W = 10;
	localparam int WORD_W = 16;
	localparam int TALLY_W = 3;
	localparam int EXT_W = 17;

	localparam logic signed [WORD_W-1:0] THRESH16 = 16'sd1024;
	localparam logic signed [WORD_W-1:0] NEG_THRESH16 = -16'sd1024;
	localparam logic signed [EXT_W-1:0] THRESH_EXT = 17'sd1024;
	localparam logic signed [EXT_W-1:0] NEG_THRESH_EXT = -17'sd1024;
	localparam logic signed [WORD_W-1:0] MAX_RESET = 16'sd2048;
	localparam logic signed [WORD_W-1:0] MIN_RESET = -16'sd2048;
	localparam logic [TALLY_W-1:0] TALLY_WRAP = 3'd6;

	localparam logic [31:0] DIVIDEND = 32'd4096000000;
	localparam logic [WORD_W-1:0] MILLION_LO = 16'(32'd1000000);
	localparam logic signed [17:0] OFFSET_MUL = 18'sd100000;
	localparam int PROD_W = 35;
	localparam int OFF_SHIFT = 12;
	localparam logic signed [PROD_W-1:0] OFF_ROUND = PROD_W'((1 << OFF_SHIFT) - 1);

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic operation;
		logic signed [WORD_W-1:0] accel_x;
		logic signed [WORD_W-1:0] accel_y;
		logic signed [WORD_W-1:0] accel_z;
	} in_word_t;

	typedef struct packed {
		logic [SL_W-1:0] samples_left;
		logic run_done;
		logic [TALLY_W-1:0] runs_completed;
		logic signed [WORD_W-1:0] scale_x;
		logic signed [WORD_W-1:0] scale_y;
		logic signed [WORD_W-1:0] scale_z;
		logic signed [WORD_W-1:0] offset_x;
		logic signed [WORD_W-1:0] offset_y;
		logic signed [WORD_W-1:0] offset_z;
	} out_word_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic store_off;
		logic store_scale;
		logic emit;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic div_done;
	} status_t;

endpackage
`default_nettype wire

### hdl/aspc_div.sv
// Restoring serial divider: fixed dividend, 16-bit divisor, one quotient bit a cycle.
`default_nettype none
module aspc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	localparam int STEPS = 32;
	localparam int CNT_W = $clog2(STEPS);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0] dvs_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [16:0] shifted;
	logic [16:0] trial;

	assign shifted = {rem_q, quo_q[31]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A borrow out of the trial subtraction means the divisor did not fit.
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= aspc_pkg::DIVIDEND;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### hdl/aspc_datapath.sv
// Datapath: sums, extremes, countdown, calibration words and the result register.
`default_nettype none
module aspc_datapath #(
	parameter int LOG2_SAMPLES = aspc_pkg::LOG2_SAMPLES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_data,
	input  wire aspc_pkg::in_word_t  in_word,
	input  wire aspc_pkg::cmd_t      cmd,
	output aspc_pkg::status_t        status,
	output aspc_pkg::out_word_t      out_word
);

	localparam int SUM_BITS = LOG2_SAMPLES + 17;
	localparam int CNT_W = LOG2_SAMPLES + 1;
	localparam logic [CNT_W-1:0] CNT_LOAD = {1'b1, {LOG2_SAMPLES{1'b0}}};

	logic apply_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [aspc_pkg::TALLY_W-1:0] tally_q;
	logic signed [SUM_BITS-1:0] pos_q [3];
	logic signed [SUM_BITS-1:0] neg_q [3];
	logic signed [SUM_BITS-1:0] pos_nx [3];
	logic signed [SUM_BITS-1:0] neg_nx [3];
	logic signed [aspc_pkg::EXT_W-1:0] hi [3];
	logic signed [aspc_pkg::EXT_W-1:0] lo [3];
	logic signed [15:0] max_q [3];
	logic signed [15:0] min_q [3];
	logic signed [15:0] acc_in [3];
	logic sample_go;
	logic last;

	assign acc_in[0] = in_word.accel_x;
	assign acc_in[1] = in_word.accel_y;
	assign acc_in[2] = in_word.accel_z;

	assign sample_go = cmd.accept && !in_word.operation && (cnt_q != '0);
	assign last = sample_go && (cnt_q == CNT_W'(1));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos_nx[i] = pos_q[i];
			neg_nx[i] = neg_q[i];
			if (acc_in[i] > aspc_pkg::THRESH16) begin
				pos_nx[i] = pos_q[i] + {{(SUM_BITS-16){acc_in[i][15]}}, acc_in[i]};
			end
			if (acc_in[i] < aspc_pkg::NEG_THRESH16) begin
				neg_nx[i] = neg_q[i] + {{(SUM_BITS-16){acc_in[i][15]}}, acc_in[i]};
			end
			hi[i] = aspc_pkg::EXT_W'(pos_nx[i] >>> LOG2_SAMPLES);
			lo[i] = aspc_pkg::EXT_W'(neg_nx[i] >>> LOG2_SAMPLES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apply_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			tally_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				neg_q[i] <= '0;
				max_q[i] <= aspc_pkg::MAX_RESET;
				min_q[i] <= aspc_pkg::MIN_RESET;
			end
		end else begin
			if (cfg_we) begin
				apply_q <= cfg_data;
			end
			if (cmd.accept) begin
				done_q <= last;
				if (in_word.operation) begin
					cnt_q <= CNT_LOAD;
				end
			end
			if (sample_go) begin
				cnt_q <= cnt_q - CNT_W'(1);
				for (int i = 0; i < 3; i++) begin
					if (last) begin
						if (hi[i] > aspc_pkg::THRESH_EXT) begin
							max_q[i] <= hi[i][15:0];
						end
						if (lo[i] < aspc_pkg::NEG_THRESH_EXT) begin
							min_q[i] <= lo[i][15:0];
						end
						pos_q[i] <= '0;
						neg_q[i] <= '0;
					end else begin
						pos_q[i] <= pos_nx[i];
						neg_q[i] <= neg_nx[i];
					end
				end
				if (last) begin
					tally_q <= (tally_q == aspc_pkg::TALLY_WRAP) ? '0
						: tally_q + aspc_pkg::TALLY_W'(1);
				end
			end
		end
	end

	// Word computation for the axis the controller selects.
	logic signed [15:0] sel_max;
	logic signed [15:0] sel_min;
	logic signed [16:0] diff;
	logic signed [16:0] ssum;
	logic signed [17:0] nsum;
	logic [15:0] dmag;
	logic [31:0] quot;
	logic div_done;

	assign sel_max = max_q[cmd.axis];
	assign sel_min = min_q[cmd.axis];
	assign diff = {sel_max[15], sel_max} - {sel_min[15], sel_min};
	assign ssum = {sel_max[15], sel_max} + {sel_min[15], sel_min};
	assign nsum = -{ssum[16], ssum};
	assign dmag = diff[16] ? 16'(-diff) : diff[15:0];

	aspc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.divisor  (dmag),
		.done     (div_done),
		.quotient (quot)
	);

	logic [1:0] axis_s1;
	logic d_neg_s1;
	logic d_zero_s1;
	logic signed [aspc_pkg::PROD_W-1:0] prod_s1;
	logic signed [aspc_pkg::PROD_W-1:0] o_rnd;
	logic [15:0] o_word;
	logic [15:0] q16;
	logic [15:0] scale_q [3];
	logic [15:0] off_q [3];
	aspc_pkg::out_word_t out_q;

	// Division by 4096 truncates toward zero, so a negative product is biased first.
	assign o_rnd = prod_s1 + (prod_s1[aspc_pkg::PROD_W-1] ? aspc_pkg::OFF_ROUND : '0);
	assign o_word = o_rnd[aspc_pkg::OFF_SHIFT +: 16];

	always_comb begin
		q16 = d_neg_s1 ? 16'(-quot[15:0]) : quot[15:0];
		if (d_zero_s1) begin
			q16 = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			axis_s1 <= cmd.axis;
			d_neg_s1 <= diff[16];
			d_zero_s1 <= (diff == '0);
			prod_s1 <= nsum * aspc_pkg::OFFSET_MUL;
		end
		if (cmd.store_off) begin
			off_q[axis_s1] <= (axis_s1 == aspc_pkg::AXIS_Z) ? 16'(-o_word) : o_word;
		end
		if (cmd.store_scale) begin
			scale_q[axis_s1] <= q16 - aspc_pkg::MILLION_LO;
		end
		if (cmd.emit) begin
			out_q.samples_left <= aspc_pkg::SL_W'(cnt_q);
			out_q.run_done <= done_q;
			out_q.runs_completed <= tally_q;
			out_q.scale_x <= apply_q ? scale_q[0] : '0;
			out_q.scale_y <= apply_q ? scale_q[1] : '0;
			out_q.scale_z <= apply_q ? scale_q[2] : '0;
			out_q.offset_x <= apply_q ? off_q[0] : '0;
			out_q.offset_y <= apply_q ? off_q[1] : '0;
			out_q.offset_z <= apply_q ? off_q[2] : '0;
		end
	end

	assign status.done = done_q;
	assign status.div_done = div_done;
	assign out_word = out_q;

endmodule
`default_nettype wire

### hdl/aspc_ctrl.sv
// Controller: handshakes and the sequence of the per-axis word computation.
`default_nettype none
module aspc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire aspc_pkg::status_t status,
	output aspc_pkg::cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_OFFS,
		ST_DIVW,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [1:0] axis_q;
	logic fresh_q;
	logic out_valid_q;
	logic emit;

	assign emit = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= aspc_pkg::AXIS_X;
			fresh_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				// The words change only when a run ends, and once after reset.
				ST_CHECK: begin
					if (status.done || !fresh_q) begin
						axis_q <= aspc_pkg::AXIS_X;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_LOAD: begin
					state_q <= ST_OFFS;
				end
				ST_OFFS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (status.div_done) begin
						if (axis_q == aspc_pkg::AXIS_Z) begin
							fresh_q <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							axis_q <= axis_q + 2'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.load = (state_q == ST_LOAD);
		cmd.store_off = (state_q == ST_OFFS);
		cmd.store_scale = (state_q == ST_DIVW) && status.div_done;
		cmd.emit = emit;
		cmd.axis = axis_q;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### hdl/accel_six_point_calibrator.sv
// Top level of the six-point accelerometer calibrator.
// Each input word is a three-axis sample or a start command that loads a countdown of
// 2**LOG2_SAMPLES samples; during the countdown readings beyond +/-1024 are summed per
// axis, and the sample that ends the run turns the averaged sums into new extremes.
// Every word yields one result word with the countdown, the done flag, the run tally
// and six scale/offset words (zeros while apply_cal is low). A word that does not end
// a run passes through the check and emit states into the result register, and the
// next word is accepted once the controller is back in idle. The word that ends
// a run, and the first word after reset, also recompute the calibration words through
// one shared 32-step serial divider, three axes in turn.
// A new word is accepted while the previous result still waits in the output register.
`default_nettype none
module accel_six_point_calibrator #(
	parameter int LOG2_SAMPLES = aspc_pkg::LOG2_SAMPLES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire aspc_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output aspc_pkg::out_word_t      out_word,
	input  wire logic                cfg_we,
	input  wire logic                cfg_data
);

	aspc_pkg::cmd_t cmd;
	aspc_pkg::status_t status;

	aspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	aspc_datapath #(
		.LOG2_SAMPLES (LOG2_SAMPLES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_word  (in_word),
		.cmd      (cmd),
		.status   (status),
		.out_word (out_word)
	);

endmodule
`default_nettype wire

### hdl/aspc_checker.sv
// Port-level checker for the calibrator, bound to the top level.
`default_nettype none
`include "accel_six_point_calibrator_macros.svh"
module aspc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire aspc_pkg::out_word_t out_word
);

	// The block works on one word at a time.
	`ASPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"ready after accept")
	`ASPC_ASSERT_SAME(a_done_count_zero, out_valid && out_word.run_done,
		out_word.samples_left == '0, "run done with samples left")
	`ASPC_ASSERT_SAME(a_tally_range, out_valid, out_word.runs_completed != 3'd7,
		"run tally past wrap")
	`ASPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word),
		"stalled word changed")

endmodule

bind accel_six_point_calibrator aspc_checker u_aspc_checker (.*);
`default_nettype wire

### tb/tb_accel_six_point_calibrator.sv
// Self-checking testbench for the six-point accelerometer calibrator.
`default_nettype none
module tb_accel_six_point_calibrator;

	localparam int LOG2_N = aspc_pkg::LOG2_SAMPLES_DEF;
	localparam int SUM_W = LOG2_N + 17;
	localparam int ITEMS_TOTAL = 950;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	aspc_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	aspc_pkg::out_word_t out_word;
	logic cfg_we = 1'b0;
	logic cfg_data = 1'b0;

	accel_six_point_calibrator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// Predicted calibrator state.
	logic signed [SUM_W-1:0] pos_sum [3];
	logic signed [SUM_W-1:0] neg_sum [3];
	logic signed [15:0] axis_max [3];
	logic signed [15:0] axis_min [3];
	logic [10:0] countdown_q;
	logic [2:0] tally_q;
	logic cal_on;

	aspc_pkg::out_word_t cal_words_due [$];
	int mismatch_count = 0;
	int items_sent = 0;
	bit no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic aspc_pkg::out_word_t predict_cal_word(input aspc_pkg::in_word_t w);
		aspc_pkg::out_word_t r;
		logic signed [15:0] a [3];
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		logic signed [15:0] sc [3];
		logic signed [15:0] of [3];
		longint mx;
		longint mn;
		longint q;
		longint o;
		a[0] = w.accel_x;
		a[1] = w.accel_y;
		a[2] = w.accel_z;
		r = '0;
		if (w.operation) begin
			countdown_q = 11'(1 << LOG2_N);
		end else if (countdown_q > 0) begin
			for (int i = 0; i < 3; i++) begin
				if (a[i] > 16'sd1024)
					pos_sum[i] = pos_sum[i] + a[i];
				if (a[i] < -16'sd1024)
					neg_sum[i] = neg_sum[i] + a[i];
			end
			if (countdown_q == 1) begin
				for (int i = 0; i < 3; i++) begin
					hi = pos_sum[i] >>> LOG2_N;
					lo = neg_sum[i] >>> LOG2_N;
					// Averages beyond int16 are kept as their low 16 bits.
					if (hi > 1024)
						axis_max[i] = hi[15:0];
					if (lo < -1024)
						axis_min[i] = lo[15:0];
					pos_sum[i] = '0;
					neg_sum[i] = '0;
				end
				if (tally_q == 3'd6)
					tally_q = 3'd0;
				else
					tally_q = tally_q + 3'd1;
				r.run_done = 1'b1;
			end
			countdown_q = countdown_q - 11'd1;
		end
		for (int i = 0; i < 3; i++) begin
			sc[i] = '0;
			of[i] = '0;
			if (cal_on) begin
				mx = axis_max[i];
				mn = axis_min[i];
				q = (mx != mn) ? 64'sd4096000000 / (mx - mn) : 64'sd0;
				o = -(mx + mn) * 100000 / 4096;
				sc[i] = 16'(q - 64'sd1000000);
				of[i] = (i == 2) ? 16'(-o) : 16'(o);
			end
		end
		r.samples_left = countdown_q[9:0];
		r.runs_completed = tally_q;
		r.scale_x = sc[0];
		r.scale_y = sc[1];
		r.scale_z = sc[2];
		r.offset_x = of[0];
		r.offset_y = of[1];
		r.offset_z = of[2];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// A reading that lands above +1024 with ph percent, below -1024 with pl percent.
	function automatic logic signed [15:0] rand_reading(input int ph, input int pl);
		int r;
		r = $urandom_range(0, 99);
		if (r < ph)
			return 16'($urandom_range(1025, 32767));
		if (r < ph + pl)
			return 16'(-int'($urandom_range(1025, 32768)));
		if (r < 97)
			return 16'(int'($urandom_range(0, 2048)) - 1024);
		return 16'($urandom);
	endfunction

	// Receiver side: random stalls, none begun while no_idle is set.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 9) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic check_field(input string field, input int due, input int got);
		if (due != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, due, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		aspc_pkg::out_word_t due;
		if (arst_n && out_valid && out_ready) begin
			if (cal_words_due.size() == 0) begin
				$display("%0t: unexpected result word %p", $time, out_word);
				mismatch_count++;
			end else begin
				due = cal_words_due.pop_front();
				check_field("samples_left", int'(due.samples_left), int'(out_word.samples_left));
				check_field("run_done", int'(due.run_done), int'(out_word.run_done));
				check_field("runs_completed", int'(due.runs_completed),
					int'(out_word.runs_completed));
				check_field("scale_x", int'(due.scale_x), int'(out_word.scale_x));
				check_field("scale_y", int'(due.scale_y), int'(out_word.scale_y));
				check_field("scale_z", int'(due.scale_z), int'(out_word.scale_z));
				check_field("offset_x", int'(due.offset_x), int'(out_word.offset_x));
				check_field("offset_y", int'(due.offset_y), int'(out_word.offset_y));
				check_field("offset_z", int'(due.offset_z), int'(out_word.offset_z));
			end
		end
	end

	// Every call starts and ends on a rising edge; valid stays high across back-to-back words.
	task automatic send_word(input logic op, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z);
		aspc_pkg::in_word_t w;
		int gap;
		w.operation = op;
		w.accel_x = x;
		w.accel_y = y;
		w.accel_z = z;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		cal_words_due.push_back(predict_cal_word(w));
		items_sent++;
	endtask

	task automatic send_start();
		send_word(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// Samples whose per-axis mix of high, low and quiet readings is drawn once per call.
	task automatic send_run(input int n);
		int ph [3];
		int pl [3];
		for (int i = 0; i < 3; i++) begin
			ph[i] = $urandom_range(0, 100);
			pl[i] = $urandom_range(0, 100 - ph[i]);
		end
		repeat (n)
			send_word(1'b0, rand_reading(ph[0], pl[0]), rand_reading(ph[1], pl[1]),
				rand_reading(ph[2], pl[2]));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (cal_words_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_apply_cal(input logic v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cal_on = v;
	endtask

	// Idle samples at the field extremes, with calibration words off and then on.
	task automatic test_idle_words();
		for (int pass = 0; pass < 2; pass++) begin
			send_word(1'b0, 16'sh7FFF, 16'sh8000, 16'sd0);
			send_word(1'b0, 16'sd1024, -16'sd1024, 16'sd1025);
			send_word(1'b0, -16'sd1025, 16'sh7FFF, -16'sd1);
			send_word(1'b0, 16'sh8000, 16'sd0, 16'sh7FFF);
			if (pass == 0)
				write_apply_cal(1'b1);
		end
	endtask

	// A restart during a run keeps the sums, so the X and Y averages of the full run
	// that follows land beyond int16; the first samples go back to back.
	task automatic test_restart_run();
		send_start();
		no_idle = 1'b1;
		repeat (20)
			send_word(1'b0, 16'sh7FFF, 16'sh8000, rand_reading(50, 50));
		no_idle = 1'b0;
		send_start();
		for (int n = 0; n < 512; n++)
			case (n % 4)
				0: send_word(1'b0, 16'sh7FFF, 16'sh8000, 16'sd1025);
				1: send_word(1'b0, 16'sh7FFF, 16'sh8000, -16'sd1025);
				2: send_word(1'b0, 16'sh7FFF, 16'sh8000, 16'sd1024);
				default: send_word(1'b0, 16'sh7FFF, 16'sh8000, -16'sd1024);
			endcase
		send_word(1'b0, 16'sd5, -16'sd5, 16'sd0);
	endtask

	// Partial runs, short bursts of arbitrary words and register writes.
	task automatic test_random();
		int pick;
		int k;
		while (items_sent < ITEMS_TOTAL) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				k = $urandom_range(1, 60);
				send_start();
				send_run(k);
			end else if (pick < 96) begin
				k = $urandom_range(1, 8);
				repeat (k)
					send_word($urandom_range(0, 4) == 0, 16'($urandom), 16'($urandom),
						16'($urandom));
			end else begin
				write_apply_cal(1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			pos_sum[i] = '0;
			neg_sum[i] = '0;
			axis_max[i] = 16'sd2048;
			axis_min[i] = -16'sd2048;
		end
		countdown_q = '0;
		tally_q = '0;
		cal_on = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_words();
		test_restart_run();
		test_random();

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

### accel_six_point_calibrator.f
+incdir+hdl
hdl/aspc_pkg.sv
hdl/aspc_div.sv
hdl/aspc_datapath.sv
hdl/aspc_ctrl.sv
hdl/accel_six_point_calibrator.sv
hdl/aspc_checker.sv
tb/tb_accel_six_point_calibrator.sv
